FILE: hw/rtl/psdb_pkg.sv
// Shared types and constants for the palette scan-out block.
package psdb_pkg;

  localparam int MAX_PIXELS   = 131072;
  localparam int PALETTE_SIZE = 256;

  localparam int FRAME_DEPTH = 2 * MAX_PIXELS;
  localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
  localparam int PAL_DEPTH   = 2 * PALETTE_SIZE;
  localparam int PAL_AW      = $clog2(PAL_DEPTH);

  localparam int COL_W  = 11;
  localparam int LINE_W = 10;
  localparam int POS_W  = COL_W + LINE_W;
  localparam int CFG_W  = 11;
  localparam int CFG_AW = 2;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [COL_W-1:0]  LINE_WIDTH_RST  = 11'd320;
  localparam logic [LINE_W-1:0] FRAME_LINES_RST = 10'd240;

  // item kinds
  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_SWAP    = 2'd2;
  localparam logic [1:0] KIND_SCAN    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_DOUBLE_BUFFER = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LINE_WIDTH    = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_FRAME_LINES   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] pixel_addr;
    logic [7:0]  color_index;
    logic [15:0] palette_color;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_rgb565;
    logic        line_end;
    logic        frame_end;
  } out_item_t;

endpackage

FILE: hw/rtl/palette_scanout_double_buffer.sv
// Indexed framebuffer scan-out through an RGB565 palette, with double buffering.
//
// Input channel (in_valid / in_stall / in_item) takes four kinds of beat:
// pixel write, palette write, swap request and scan tick. Only a scan tick
// produces a result beat on the output channel (out_valid / out_stall /
// out_item), carrying the colour plus line_end and frame_end marks.
// One input beat is accepted per cycle while in_stall is low. A scan tick's
// result passes through the position multiply, the frame memory read, the
// palette memory read and the write into the output queue, in that order,
// before it is available. The frame memory has one write and one read
// port; each beat uses one of them in its own pipeline slot, so the block
// sustains one beat per cycle while in_stall is low.
// After reset both memories are cleared, one frame entry per cycle, over all
// 262144 frame entries (2 * MAX_PIXELS); in_stall is high for that time. Config
// writes are taken at any time. When the receiver stalls, results collect
// in an 8-entry output queue; in_stall rises once 8 scan results are in
// flight or queued, so nothing is dropped.
module palette_scanout_double_buffer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  psdb_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output psdb_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [psdb_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [psdb_pkg::CFG_W-1:0]    cfg_wdata
);

  // configuration
  logic                          dbuf_r;
  logic [psdb_pkg::COL_W-1:0]    lwidth_r;
  logic [psdb_pkg::LINE_W-1:0]   flines_r;

  // raster / swap state
  logic                          back_sel_r, back_sel_nxt;
  logic                          swap_pend_r, swap_pend_nxt;
  logic [psdb_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [psdb_pkg::LINE_W-1:0]   line_r, line_nxt;

  // clearing pass
  logic                          clr_r;
  logic [psdb_pkg::FRAME_AW-1:0] clr_addr_r;

  // memories
  logic [7:0]  frame_mem [psdb_pkg::FRAME_DEPTH];
  logic [15:0] pal_mem   [psdb_pkg::PAL_DEPTH];
  logic [7:0]  frame_rd_r;
  logic [15:0] pal_rd_r;

  // stage 1
  logic                          s1_vld_r;
  logic [1:0]                    s1_kind_r;
  logic [16:0]                   s1_addr_r;
  logic [7:0]                    s1_cidx_r;
  logic [15:0]                   s1_pcol_r;
  logic                          s1_bank_r, s1_le_r, s1_fe_r;
  logic [psdb_pkg::COL_W-1:0]    s1_ma_r;
  logic [psdb_pkg::LINE_W-1:0]   s1_mb_r;
  logic [psdb_pkg::COL_W-1:0]    s1_add_r;

  // stage 2
  logic                          s2_vld_r;
  logic [1:0]                    s2_kind_r;
  logic [16:0]                   s2_addr_r;
  logic [7:0]                    s2_cidx_r;
  logic [15:0]                   s2_pcol_r;
  logic                          s2_bank_r, s2_le_r, s2_fe_r;
  logic [psdb_pkg::POS_W-1:0]    s2_prod_r;

  // stage 3 / 4
  logic                          s3_scan_r, s3_inrng_r, s3_bank_r, s3_le_r, s3_fe_r;
  logic                          s4_scan_r, s4_le_r, s4_fe_r;

  // output queue
  psdb_pkg::out_item_t           oq_mem [psdb_pkg::OQ_DEPTH];
  logic [psdb_pkg::OQ_AW-1:0]    oq_wr_r, oq_rd_r;
  logic [psdb_pkg::OQ_CW-1:0]    oq_cnt_r;
  logic [psdb_pkg::OQ_CW-1:0]    used_r;

  logic                          in_acc, out_acc, acc_scan;
  logic [psdb_pkg::COL_W-1:0]    w_eff;
  logic [psdb_pkg::LINE_W-1:0]   h_eff;
  logic                          le, fe, draw_bank, show_bank;
  logic [psdb_pkg::POS_W-1:0]    prod;
  logic                          fwe, wr_ok, s2_scan, s2_inrng;
  logic [psdb_pkg::FRAME_AW-1:0] fwaddr, fraddr, s2_off;
  logic [7:0]                    fwdata, pix_idx;
  logic                          pwe;
  logic [psdb_pkg::PAL_AW-1:0]   pwaddr, praddr;
  logic [15:0]                   pwdata;

  assign in_stall  = clr_r || (used_r == psdb_pkg::OQ_CW'(psdb_pkg::OQ_DEPTH));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (oq_cnt_r != '0);
  assign out_acc   = out_valid && !out_stall;
  assign out_item  = oq_mem[oq_rd_r];
  assign acc_scan  = in_acc && (in_item.kind == psdb_pkg::KIND_SCAN);

  assign w_eff     = (lwidth_r == '0) ? psdb_pkg::COL_W'(1) : lwidth_r;
  assign h_eff     = (flines_r == '0) ? psdb_pkg::LINE_W'(1) : flines_r;
  assign draw_bank = dbuf_r & back_sel_r;
  assign show_bank = dbuf_r & ~back_sel_r;

  // raster advance and swap at accept time
  always_comb begin
    le            = ({1'b0, col_r} + 12'd1) >= {1'b0, w_eff};
    fe            = le && (({1'b0, line_r} + 11'd1) >= {1'b0, h_eff});
    col_nxt       = col_r;
    line_nxt      = line_r;
    back_sel_nxt  = back_sel_r;
    swap_pend_nxt = swap_pend_r;
    if (in_acc && in_item.kind == psdb_pkg::KIND_SWAP && dbuf_r) begin
      swap_pend_nxt = 1'b1;
    end
    if (acc_scan) begin
      if (le) begin
        col_nxt = '0;
        if (fe) begin
          line_nxt = '0;
          if (swap_pend_r) begin
            back_sel_nxt  = ~back_sel_r;
            swap_pend_nxt = 1'b0;
          end
        end else begin
          line_nxt = line_r + psdb_pkg::LINE_W'(1);
        end
      end else begin
        col_nxt = col_r + psdb_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbuf_r      <= 1'b0;
      lwidth_r    <= psdb_pkg::LINE_WIDTH_RST;
      flines_r    <= psdb_pkg::FRAME_LINES_RST;
      back_sel_r  <= 1'b0;
      swap_pend_r <= 1'b0;
      col_r       <= '0;
      line_r      <= '0;
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          psdb_pkg::CFG_DOUBLE_BUFFER: dbuf_r   <= cfg_wdata[0];
          psdb_pkg::CFG_LINE_WIDTH:    lwidth_r <= cfg_wdata[psdb_pkg::COL_W-1:0];
          psdb_pkg::CFG_FRAME_LINES:   flines_r <= cfg_wdata[psdb_pkg::LINE_W-1:0];
          default: ;
        endcase
      end
      back_sel_r  <= back_sel_nxt;
      swap_pend_r <= swap_pend_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + psdb_pkg::FRAME_AW'(1);
        if (clr_addr_r == psdb_pkg::FRAME_AW'(psdb_pkg::FRAME_DEPTH - 1)) begin
          clr_r <= 1'b0;
        end
      end
    end
  end

  // stage 1: operand capture; scan uses line*w+col, pixel write uses w*h
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
    s1_kind_r <= in_item.kind;
    s1_addr_r <= in_item.pixel_addr;
    s1_cidx_r <= in_item.color_index;
    s1_pcol_r <= in_item.palette_color;
    s1_bank_r <= (in_item.kind == psdb_pkg::KIND_SCAN) ? show_bank : draw_bank;
    s1_le_r   <= le;
    s1_fe_r   <= fe;
    s1_ma_r   <= w_eff;
    s1_mb_r   <= (in_item.kind == psdb_pkg::KIND_SCAN) ? line_r : h_eff;
    s1_add_r  <= (in_item.kind == psdb_pkg::KIND_SCAN) ? col_r : '0;
  end

  assign prod = psdb_pkg::POS_W'(s1_ma_r) * psdb_pkg::POS_W'(s1_mb_r) +
                psdb_pkg::POS_W'(s1_add_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_kind_r <= s1_kind_r;
    s2_addr_r <= s1_addr_r;
    s2_cidx_r <= s1_cidx_r;
    s2_pcol_r <= s1_pcol_r;
    s2_bank_r <= s1_bank_r;
    s2_le_r   <= s1_le_r;
    s2_fe_r   <= s1_fe_r;
    s2_prod_r <= prod;
  end

  // stage 2: frame memory access, palette write
  always_comb begin
    s2_off   = s2_bank_r ? psdb_pkg::FRAME_AW'(psdb_pkg::MAX_PIXELS) : '0;
    s2_scan  = s2_vld_r && (s2_kind_r == psdb_pkg::KIND_SCAN);
    s2_inrng = s2_prod_r < psdb_pkg::POS_W'(psdb_pkg::MAX_PIXELS);
    wr_ok    = ({{(psdb_pkg::POS_W-17){1'b0}}, s2_addr_r} < s2_prod_r) &&
               (32'(s2_addr_r) < 32'(psdb_pkg::MAX_PIXELS));
    fraddr   = s2_off + psdb_pkg::FRAME_AW'(s2_prod_r);
    if (clr_r) begin
      fwe    = 1'b1;
      fwaddr = clr_addr_r;
      fwdata = '0;
    end else begin
      fwe    = s2_vld_r && (s2_kind_r == psdb_pkg::KIND_PIXEL) && wr_ok;
      fwaddr = s2_off + psdb_pkg::FRAME_AW'(s2_addr_r);
      fwdata = s2_cidx_r;
    end
    if (clr_r) begin
      pwe    = (32'(clr_addr_r) < 32'(psdb_pkg::PAL_DEPTH));
      pwaddr = clr_addr_r[psdb_pkg::PAL_AW-1:0];
      pwdata = '0;
    end else begin
      pwe    = s2_vld_r && (s2_kind_r == psdb_pkg::KIND_PALETTE);
      pwaddr = psdb_pkg::PAL_AW'(s2_cidx_r) +
               (s2_bank_r ? psdb_pkg::PAL_AW'(psdb_pkg::PALETTE_SIZE) : '0);
      pwdata = s2_pcol_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      frame_mem[fwaddr] <= fwdata;
    end
    frame_rd_r <= frame_mem[fraddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_scan_r <= 1'b0;
    end else begin
      s3_scan_r <= s2_scan;
    end
    s3_inrng_r <= s2_inrng;
    s3_bank_r  <= s2_bank_r;
    s3_le_r    <= s2_le_r;
    s3_fe_r    <= s2_fe_r;
  end

  // stage 3: palette lookup; a read here sees old data against a same-cycle write
  assign pix_idx = s3_inrng_r ? frame_rd_r : 8'd0;
  assign praddr  = psdb_pkg::PAL_AW'(pix_idx) +
                   (s3_bank_r ? psdb_pkg::PAL_AW'(psdb_pkg::PALETTE_SIZE) : '0);

  always_ff @(posedge clk) begin
    if (pwe) begin
      pal_mem[pwaddr] <= pwdata;
    end
    pal_rd_r <= pal_mem[praddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_scan_r <= 1'b0;
    end else begin
      s4_scan_r <= s3_scan_r;
    end
    s4_le_r <= s3_le_r;
    s4_fe_r <= s3_fe_r;
  end

  // output queue; used_r counts scan beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (s4_scan_r) begin
      oq_mem[oq_wr_r] <= '{pixel_rgb565: pal_rd_r, line_end: s4_le_r, frame_end: s4_fe_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
      used_r   <= '0;
    end else begin
      if (s4_scan_r) begin
        oq_wr_r <= oq_wr_r + psdb_pkg::OQ_AW'(1);
      end
      if (out_acc) begin
        oq_rd_r <= oq_rd_r + psdb_pkg::OQ_AW'(1);
      end
      case ({s4_scan_r, out_acc})
        2'b10:   oq_cnt_r <= oq_cnt_r + psdb_pkg::OQ_CW'(1);
        2'b01:   oq_cnt_r <= oq_cnt_r - psdb_pkg::OQ_CW'(1);
        default: oq_cnt_r <= oq_cnt_r;
      endcase
      case ({acc_scan, out_acc})
        2'b10:   used_r <= used_r + psdb_pkg::OQ_CW'(1);
        2'b01:   used_r <= used_r - psdb_pkg::OQ_CW'(1);
        default: used_r <= used_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= psdb_pkg::OQ_CW'(psdb_pkg::OQ_DEPTH))
    else $error("in-flight scan count exceeds output queue depth");

  a_queue_subset: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= used_r)
    else $error("output queue holds more beats than were accepted");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    s4_scan_r |-> (oq_cnt_r != psdb_pkg::OQ_CW'(psdb_pkg::OQ_DEPTH)) || out_acc)
    else $error("push into full output queue");

  a_scan_latency: assert property (@(posedge clk) disable iff (!rst_n)
    s4_scan_r |-> $past(acc_scan, 4))
    else $error("scan result without matching accepted scan tick");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !out_valid && !s2_vld_r)
    else $error("pipeline active during memory clear");
`endif

endmodule

FILE: tb/palette_scanout_double_buffer_tb.sv
// Self-checking testbench for the palette scan-out block with double buffering.
`timescale 1ns / 100ps

module palette_scanout_double_buffer_tb;

  localparam int unsigned CYCLE_LIMIT = 900_000;
  localparam int          SETTLE_CYCLES = 12;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  psdb_pkg::in_item_t            in_item;
  logic                          out_valid;
  logic                          out_stall;
  psdb_pkg::out_item_t           out_item;
  logic                          cfg_we;
  logic [psdb_pkg::CFG_AW-1:0]   cfg_index;
  logic [psdb_pkg::CFG_W-1:0]    cfg_wdata;

  // shadow of the display state
  bit [7:0]    frame_mem [0:psdb_pkg::FRAME_DEPTH-1];
  bit [15:0]   pal_mem [0:psdb_pkg::PAL_DEPTH-1];
  bit          back_sel;
  bit          swap_pend;
  bit [psdb_pkg::COL_W-1:0]  col_cnt;
  bit [psdb_pkg::LINE_W-1:0] line_cnt;
  bit          double_buf_r;
  bit [psdb_pkg::COL_W-1:0]  line_width_r;
  bit [psdb_pkg::LINE_W-1:0] frame_lines_r;

  psdb_pkg::out_item_t expected_pixels [$];

  bit          tx_idle_on;
  bit          rx_idle_on;
  int          beats_sent;
  int          pixels_checked;
  int          frame_ends;
  int          swaps_done;
  int          mismatches;
  int unsigned cycle_count = 0;

  palette_scanout_double_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Advances the shadow display by one accepted beat; scan ticks queue a pixel.
  function automatic void apply_beat(psdb_pkg::in_item_t it);
    int unsigned w, h, pos, draw, shown;
    bit [7:0]    idx;
    psdb_pkg::out_item_t px;
    w = (line_width_r == 0) ? 1 : line_width_r;
    h = (frame_lines_r == 0) ? 1 : frame_lines_r;
    draw = double_buf_r ? back_sel : 0;
    shown = double_buf_r ? !back_sel : 0;
    case (it.kind)
      psdb_pkg::KIND_PIXEL: begin
        if (it.pixel_addr < w * h && it.pixel_addr < psdb_pkg::MAX_PIXELS)
          frame_mem[draw * psdb_pkg::MAX_PIXELS + it.pixel_addr] = it.color_index;
      end
      psdb_pkg::KIND_PALETTE: begin
        pal_mem[draw * psdb_pkg::PALETTE_SIZE + it.color_index] = it.palette_color;
      end
      psdb_pkg::KIND_SWAP: begin
        if (double_buf_r)
          swap_pend = 1'b1;
      end
      default: begin
        pos = line_cnt * w + col_cnt;
        idx = (pos < psdb_pkg::MAX_PIXELS) ?
              frame_mem[shown * psdb_pkg::MAX_PIXELS + pos] : 8'd0;
        px.pixel_rgb565 = pal_mem[shown * psdb_pkg::PALETTE_SIZE + idx];
        px.line_end = (col_cnt + 1 >= w);
        px.frame_end = px.line_end && (line_cnt + 1 >= h);
        expected_pixels.push_back(px);
        if (px.line_end) begin
          col_cnt = '0;
          if (px.frame_end) begin
            line_cnt = '0;
            if (swap_pend) begin
              back_sel = !back_sel;
              swap_pend = 1'b0;
              swaps_done++;
            end
          end else begin
            line_cnt = line_cnt + 1'b1;
          end
        end else begin
          col_cnt = col_cnt + 1'b1;
        end
      end
    endcase
  endfunction

  // Both channels are sampled at the edge, before any update of that edge lands.
  always @(posedge clk) begin : watch_channels
    psdb_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        apply_beat(in_item);
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel beat, expected none actual %h", $time, out_item);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (out_item.frame_end)
            frame_ends++;
          if (out_item.pixel_rgb565 !== want.pixel_rgb565) begin
            $display("%0t: pixel_rgb565 expected %h actual %h", $time,
                     want.pixel_rgb565, out_item.pixel_rgb565);
            mismatches++;
          end
          if (out_item.line_end !== want.line_end) begin
            $display("%0t: line_end expected %b actual %b", $time,
                     want.line_end, out_item.line_end);
            mismatches++;
          end
          if (out_item.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %b actual %b", $time,
                     want.frame_end, out_item.frame_end);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver back-pressure in random bursts
  initial begin : rx_stalls
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic psdb_pkg::in_item_t make_beat(logic [1:0] kind, logic [16:0] addr,
                                                   logic [7:0] idx, logic [15:0] color);
    psdb_pkg::in_item_t it;
    it.kind = kind;
    it.pixel_addr = addr;
    it.color_index = idx;
    it.palette_color = color;
    return it;
  endfunction

  // Called at a clock edge; returns at the edge where the beat is taken.
  task automatic send_beat(psdb_pkg::in_item_t it);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Registers change only once the pipeline has drained.
  task automatic write_reg(logic [psdb_pkg::CFG_AW-1:0] idx,
                           logic [psdb_pkg::CFG_W-1:0] val);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      psdb_pkg::CFG_DOUBLE_BUFFER: double_buf_r = val[0];
      psdb_pkg::CFG_LINE_WIDTH:    line_width_r = val;
      psdb_pkg::CFG_FRAME_LINES:   frame_lines_r = val[psdb_pkg::LINE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic scan_ticks(int n);
    repeat (n)
      send_beat(make_beat(psdb_pkg::KIND_SCAN, 17'($urandom()), 8'($urandom()),
                          16'($urandom())));
  endtask

  task automatic put_pixel(logic [16:0] addr, logic [7:0] idx);
    send_beat(make_beat(psdb_pkg::KIND_PIXEL, addr, idx, 16'($urandom())));
  endtask

  task automatic put_color(logic [7:0] idx, logic [15:0] color);
    send_beat(make_beat(psdb_pkg::KIND_PALETTE, 17'($urandom()), idx, color));
  endtask

  task automatic request_swap();
    send_beat(make_beat(psdb_pkg::KIND_SWAP, 17'($urandom()), 8'($urandom()),
                        16'($urandom())));
  endtask

  task automatic set_geometry(logic [psdb_pkg::CFG_W-1:0] w,
                              logic [psdb_pkg::CFG_W-1:0] h);
    write_reg(psdb_pkg::CFG_LINE_WIDTH, w);
    write_reg(psdb_pkg::CFG_FRAME_LINES, h);
  endtask

  // one-pixel frame puts the raster back at the origin
  task automatic home_raster();
    set_geometry(11'd1, 11'd1);
    scan_ticks(1);
  endtask

  task automatic test_single_buffer();
    scan_ticks(2);
    home_raster();
    set_geometry(11'd4, 11'd2);
    put_color(8'd255, 16'hFFFF);
    put_color(8'd0, 16'h07E0);
    put_pixel(17'd0, 8'd255);
    put_pixel(17'd7, 8'd255);
    put_pixel(17'd8, 8'd255);        // just past the canvas
    put_pixel(17'h1FFFF, 8'd255);    // far past the canvas
    request_swap();                  // no effect in single-buffer mode
    put_pixel(17'd3, 8'd0);
    scan_ticks(8);
  endtask

  task automatic test_double_buffer();
    write_reg(psdb_pkg::CFG_DOUBLE_BUFFER, 11'd1);
    home_raster();
    set_geometry(11'd4, 11'd2);
    put_color(8'd1, 16'hF800);
    put_pixel(17'd0, 8'd1);
    put_pixel(17'd5, 8'd1);
    scan_ticks(8);
    request_swap();
    scan_ticks(8);
    scan_ticks(8);
    scan_ticks(3);
    request_swap();                  // mid-frame request waits for frame end
    put_pixel(17'd2, 8'd1);
    put_color(8'd1, 16'h001F);
    scan_ticks(5);
    scan_ticks(8);
  endtask

  task automatic test_swap_left_pending();
    write_reg(psdb_pkg::CFG_DOUBLE_BUFFER, 11'd1);
    request_swap();
    write_reg(psdb_pkg::CFG_DOUBLE_BUFFER, 11'd0);
    home_raster();                   // bank flips unseen here
    set_geometry(11'd4, 11'd2);
    scan_ticks(4);
    write_reg(psdb_pkg::CFG_DOUBLE_BUFFER, 11'd1);
    scan_ticks(8);
  endtask

  task automatic test_zero_geometry();
    write_reg(psdb_pkg::CFG_DOUBLE_BUFFER, 11'd0);
    set_geometry(11'd0, 11'd0);
    put_pixel(17'd0, 8'd3);
    put_pixel(17'd1, 8'd4);
    put_color(8'd3, 16'h5555);
    scan_ticks(3);
    set_geometry(11'd0, 11'd3);
    scan_ticks(4);
    set_geometry(11'd3, 11'd0);
    scan_ticks(4);
  endtask

  // Walks the raster to the last stored position and past it.
  task automatic test_store_edge();
    write_reg(psdb_pkg::CFG_DOUBLE_BUFFER, 11'd0);
    home_raster();
    set_geometry(11'd2047, 11'd720);
    put_pixel(17'h1FFFF, 8'hA5);
    put_color(8'hA5, 16'h1234);
    put_color(8'd0, 16'hBEEF);
    write_reg(psdb_pkg::CFG_LINE_WIDTH, 11'd1);
    scan_ticks(64);
    write_reg(psdb_pkg::CFG_LINE_WIDTH, 11'd2047);
    scan_ticks(66);
    // counters now sit past the last line and column
    set_geometry(11'd1, 11'd5);
    scan_ticks(2);
    set_geometry(11'd1280, 11'd720);
    scan_ticks(3);
  endtask

  task automatic test_random_traffic();
    int unsigned w, h, area;
    psdb_pkg::in_item_t it;
    for (int phase = 0; phase < 8; phase++) begin
      tx_idle_on = (phase != 2 && phase != 5 && phase != 7);
      rx_idle_on = tx_idle_on;
      write_reg(psdb_pkg::CFG_DOUBLE_BUFFER, psdb_pkg::CFG_W'($urandom()));
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = 1280;
        2: w = 2047;
        3: w = $urandom_range(9, 2047);
        default: w = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: h = 0;
        1: h = 720;
        2: h = 1023 + ($urandom_range(0, 1) << 10);  // bit 10 is dropped
        3: h = $urandom_range(7, 1023);
        default: h = $urandom_range(1, 6);
      endcase
      set_geometry(psdb_pkg::CFG_W'(w), psdb_pkg::CFG_W'(h));
      area = ((w == 0) ? 1 : w) * (((h % 1024) == 0) ? 1 : (h % 1024));
      if (area > psdb_pkg::MAX_PIXELS)
        area = psdb_pkg::MAX_PIXELS;
      repeat (52) begin
        case ($urandom_range(0, 9))
          0, 1, 2: it.kind = psdb_pkg::KIND_PIXEL;
          3, 4:    it.kind = psdb_pkg::KIND_PALETTE;
          5:       it.kind = psdb_pkg::KIND_SWAP;
          default: it.kind = psdb_pkg::KIND_SCAN;
        endcase
        it.pixel_addr = ($urandom_range(0, 9) < 6) ? 17'($urandom_range(0, area - 1))
                                                   : 17'($urandom());
        it.color_index = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom());
        it.palette_color = 16'($urandom());
        send_beat(it);
        if ($urandom_range(0, 59) == 0)
          wait_for_results();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    double_buf_r = 1'b0;
    line_width_r = psdb_pkg::LINE_WIDTH_RST;
    frame_lines_r = psdb_pkg::FRAME_LINES_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_single_buffer();
    test_double_buffer();
    test_swap_left_pending();
    test_zero_geometry();
    test_store_edge();
    test_random_traffic();

    wait_for_results();
    repeat (20) @(posedge clk);
    $display("covered %0d input beats, %0d pixels checked, %0d frame ends, %0d swaps",
             beats_sent, pixels_checked, frame_ends, swaps_done);
    $display("single and double buffering, late swaps, zero and odd geometry, store edge");
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
